/* sv/slfd_pkg.sv */
`default_nettype none

package slfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd3;

    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd251;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_SYNC3 = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] sync_third;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_flag;
        logic              last_flag;
        logic              empty_flag;
    } result_t;

    typedef struct packed {
        phase_t            phase;
        logic [BYTE_W-1:0] bytes_left;
    } parse_status_t;

endpackage

`default_nettype wire

/* sv/slfd_in_if.sv */
`default_nettype none

interface slfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* sv/slfd_out_if.sv */
`default_nettype none

interface slfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_flag;
    logic       last_flag;
    logic       empty_flag;

    modport source (output valid, output payload_byte, output first_flag,
                    output last_flag, output empty_flag, input ready);
    modport sink   (input valid, input payload_byte, input first_flag,
                    input last_flag, input empty_flag, output ready);
endinterface

`default_nettype wire

/* sv/slfd_cfg_regs.sv */
`default_nettype none

module slfd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slfd_pkg::BYTE_W-1:0]    cfg_data,
    output slfd_pkg::cfg_t                      cfg
);

    slfd_pkg::cfg_t cfg_reg;
    slfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                slfd_pkg::CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data;
                slfd_pkg::CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data;
                slfd_pkg::CFG_SYNC_THIRD:  cfg_next.sync_third  = cfg_data;
                slfd_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= '0;
            cfg_reg.sync_second <= '0;
            cfg_reg.sync_third  <= '0;
            cfg_reg.max_payload <= slfd_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/slfd_in_reg.sv */
`default_nettype none

module slfd_in_reg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [slfd_pkg::BYTE_W-1:0] in_byte,
    output logic                             in_ready,
    input  wire logic                        advance,
    output logic                             held_valid,
    output logic [slfd_pkg::BYTE_W-1:0]      held_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [slfd_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    // stage frees up in the same cycle its item moves on
    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

/* sv/slfd_parser.sv */
`default_nettype none

module slfd_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [slfd_pkg::BYTE_W-1:0] rx_byte,
    input  wire slfd_pkg::cfg_t              cfg,
    output logic                             has_result,
    output slfd_pkg::result_t                result,
    output slfd_pkg::parse_status_t          status
);

    slfd_pkg::phase_t            phase_reg;
    slfd_pkg::phase_t            phase_next;
    logic [slfd_pkg::BYTE_W-1:0] left_reg;
    logic [slfd_pkg::BYTE_W-1:0] left_next;
    logic                        first_reg;
    logic                        first_next;
    slfd_pkg::phase_t            restart;
    logic                        is_last;

    // a byte that breaks the pattern may itself open a new one
    assign restart = (rx_byte == cfg.sync_first) ? slfd_pkg::PH_SYNC2 : slfd_pkg::PH_SYNC1;
    assign is_last = (left_reg <= 8'd1);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        first_next = first_reg;
        has_result = 1'b0;
        result     = '0;
        unique case (phase_reg)
            slfd_pkg::PH_SYNC2:
            begin
                phase_next = (rx_byte == cfg.sync_second) ? slfd_pkg::PH_SYNC3 : restart;
            end
            slfd_pkg::PH_SYNC3:
            begin
                phase_next = (rx_byte == cfg.sync_third) ? slfd_pkg::PH_LEN : restart;
            end
            slfd_pkg::PH_LEN:
            begin
                if (rx_byte == '0)
                begin
                    phase_next        = slfd_pkg::PH_SYNC1;
                    left_next         = '0;
                    first_next        = 1'b0;
                    has_result        = 1'b1;
                    result.last_flag  = 1'b1;
                    result.empty_flag = 1'b1;
                end
                else if (rx_byte > cfg.max_payload)
                begin
                    phase_next = slfd_pkg::PH_SYNC1;
                    left_next  = '0;
                    first_next = 1'b0;
                end
                else
                begin
                    phase_next = slfd_pkg::PH_DATA;
                    left_next  = rx_byte;
                    first_next = 1'b1;
                end
            end
            slfd_pkg::PH_DATA:
            begin
                has_result          = 1'b1;
                result.payload_byte = rx_byte;
                result.first_flag   = first_reg;
                result.last_flag    = is_last;
                first_next          = 1'b0;
                if (is_last)
                begin
                    left_next  = '0;
                    phase_next = slfd_pkg::PH_SYNC1;
                end
                else
                begin
                    left_next = left_reg - 8'd1;
                end
            end
            default:
            begin
                phase_next = restart;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= slfd_pkg::PH_SYNC1;
            left_reg  <= '0;
            first_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            first_reg <= first_next;
        end
    end

    assign status.phase      = phase_reg;
    assign status.bytes_left = left_reg;

endmodule

`default_nettype wire

/* sv/slfd_out_reg.sv */
`default_nettype none

module slfd_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire slfd_pkg::result_t load_data,
    input  wire logic              out_ready,
    output logic                   out_free,
    output logic                   out_valid,
    output slfd_pkg::result_t      out_data
);

    logic              valid_reg;
    logic              valid_next;
    slfd_pkg::result_t data_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* sv/sync_length_frame_deframer_unit.sv */
// a byte accepted into the input register has its result loaded into the result register, which drives the output
// one byte per cycle, limited only by the single result register
// a byte that yields no result moves on even while the result register is stalled
// reset (rst_n low, asynchronous) empties both stages, returns to the hunt for the
// first sync byte, and loads the sync bytes with zero and max_payload with 251
`default_nettype none

module sync_length_frame_deframer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    slfd_in_if.sink                             rx,
    slfd_out_if.source                          frame,
    input  wire logic                           cfg_we,
    input  wire logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slfd_pkg::BYTE_W-1:0]    cfg_data
);

    slfd_pkg::cfg_t          cfg;
    logic                    held_valid;
    logic [slfd_pkg::BYTE_W-1:0] held_byte;
    logic                    advance;
    logic                    has_result;
    slfd_pkg::result_t       result;
    slfd_pkg::result_t       out_data;
    slfd_pkg::parse_status_t status;
    logic                    out_free;
    logic                    out_valid;

    slfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slfd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    slfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (held_byte),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result),
        .status     (status)
    );

    // the held byte moves on unless it has a result with nowhere to go
    assign advance = held_valid && (!has_result || out_free);

    slfd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_result),
        .load_data (result),
        .out_ready (frame.ready),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign frame.valid        = out_valid;
    assign frame.payload_byte = out_data.payload_byte;
    assign frame.first_flag   = out_data.first_flag;
    assign frame.last_flag    = out_data.last_flag;
    assign frame.empty_flag   = out_data.empty_flag;

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.empty_flag) |-> (frame.last_flag && !frame.first_flag))
        else $error("empty frame result not marked last only");

    a_left_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (status.phase == slfd_pkg::PH_DATA) == (status.bytes_left != '0))
        else $error("payload count out of step with phase");

    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status.phase == slfd_pkg::PH_DATA) |=> frame.valid)
        else $error("payload byte did not reach the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && !frame.ready) |=> (frame.valid && $stable(out_data)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    typedef logic [slfd_pkg::BYTE_W-1:0] byte_q_t[$];

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [slfd_pkg::BYTE_W-1:0]    cfg_data;

    slfd_in_if  rx_if ();
    slfd_out_if frame_if ();

    sync_length_frame_deframer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .frame     (frame_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // deframer model state
    slfd_pkg::cfg_t              regs;
    slfd_pkg::phase_t            parse_phase;
    logic [slfd_pkg::BYTE_W-1:0] payload_left;
    logic                        next_is_first;

    slfd_pkg::result_t expected_payload[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      hold_cycles = 0;
    bit      src_gaps_on = 1'b1;
    bit      sink_idle_on = 1'b1;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic slfd_pkg::phase_t resync_phase(input logic [slfd_pkg::BYTE_W-1:0] b);
        return (b == regs.sync_first) ? slfd_pkg::PH_SYNC2 : slfd_pkg::PH_SYNC1;
    endfunction

    function automatic void deframe_byte(input logic [slfd_pkg::BYTE_W-1:0] b);
        slfd_pkg::result_t r;
        case (parse_phase)
            slfd_pkg::PH_SYNC2:
                parse_phase = (b == regs.sync_second) ? slfd_pkg::PH_SYNC3 : resync_phase(b);
            slfd_pkg::PH_SYNC3:
                parse_phase = (b == regs.sync_third) ? slfd_pkg::PH_LEN : resync_phase(b);
            slfd_pkg::PH_LEN:
            begin
                if (b == '0)
                begin
                    r.payload_byte = '0;
                    r.first_flag   = 1'b0;
                    r.last_flag    = 1'b1;
                    r.empty_flag   = 1'b1;
                    expected_payload.push_back(r);
                    parse_phase   = slfd_pkg::PH_SYNC1;
                    payload_left  = '0;
                    next_is_first = 1'b0;
                end
                else if (b > regs.max_payload)
                begin
                    // dropped frame, this byte is not looked at as a sync byte
                    parse_phase   = slfd_pkg::PH_SYNC1;
                    payload_left  = '0;
                    next_is_first = 1'b0;
                end
                else
                begin
                    payload_left  = b;
                    next_is_first = 1'b1;
                    parse_phase   = slfd_pkg::PH_DATA;
                end
            end
            slfd_pkg::PH_DATA:
            begin
                r.payload_byte = b;
                r.first_flag   = next_is_first;
                r.last_flag    = (payload_left <= 8'd1);
                r.empty_flag   = 1'b0;
                expected_payload.push_back(r);
                next_is_first = 1'b0;
                if (r.last_flag)
                begin
                    payload_left = '0;
                    parse_phase  = slfd_pkg::PH_SYNC1;
                end
                else
                    payload_left = payload_left - 8'd1;
            end
            default: parse_phase = resync_phase(b);
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        slfd_pkg::result_t want;
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            if (expected_payload.size() == 0)
            begin
                $error("unexpected item: payload_byte %0h first %0b last %0b empty %0b",
                       frame_if.payload_byte, frame_if.first_flag,
                       frame_if.last_flag, frame_if.empty_flag);
                mismatches++;
            end
            else
            begin
                want = expected_payload.pop_front();
                if (frame_if.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, frame_if.payload_byte);
                    mismatches++;
                end
                if (frame_if.first_flag !== want.first_flag)
                begin
                    $error("first_flag: expected %0b, got %0b",
                           want.first_flag, frame_if.first_flag);
                    mismatches++;
                end
                if (frame_if.last_flag !== want.last_flag)
                begin
                    $error("last_flag: expected %0b, got %0b",
                           want.last_flag, frame_if.last_flag);
                    mismatches++;
                end
                if (frame_if.empty_flag !== want.empty_flag)
                begin
                    $error("empty_flag: expected %0b, got %0b",
                           want.empty_flag, frame_if.empty_flag);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        frame_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                frame_if.ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else if (sink_idle_on && $urandom_range(0, 11) == 0)
            begin
                frame_if.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end
            else
                frame_if.ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [slfd_pkg::BYTE_W-1:0] b);
        if (src_gaps_on && $urandom_range(0, 7) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        deframe_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input byte_q_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic idle_rx();
        rx_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (expected_payload.size() != 0);
    endtask

    task automatic write_reg(input logic [slfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slfd_pkg::BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            slfd_pkg::CFG_SYNC_FIRST:  regs.sync_first  = val;
            slfd_pkg::CFG_SYNC_SECOND: regs.sync_second = val;
            slfd_pkg::CFG_SYNC_THIRD:  regs.sync_third  = val;
            slfd_pkg::CFG_MAX_PAYLOAD: regs.max_payload = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [slfd_pkg::BYTE_W-1:0] s1,
                                input logic [slfd_pkg::BYTE_W-1:0] s2,
                                input logic [slfd_pkg::BYTE_W-1:0] s3,
                                input logic [slfd_pkg::BYTE_W-1:0] maxp);
        idle_rx();
        wait_drained();
        // a byte with no result may still be inside the pipeline
        repeat (4) @(negedge clk);
        write_reg(slfd_pkg::CFG_SYNC_FIRST, s1);
        write_reg(slfd_pkg::CFG_SYNC_SECOND, s2);
        write_reg(slfd_pkg::CFG_SYNC_THIRD, s3);
        write_reg(slfd_pkg::CFG_MAX_PAYLOAD, maxp);
        // unmapped indexes must leave every register alone
        for (int i = slfd_pkg::CFG_MAX_PAYLOAD + 1; i < (1 << slfd_pkg::CFG_IDX_W); i++)
            write_reg(i[slfd_pkg::CFG_IDX_W-1:0], 8'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [slfd_pkg::BYTE_W-1:0] pick_length();
        int r;
        int top;
        r   = $urandom_range(0, 19);
        top = (regs.max_payload < 12) ? regs.max_payload : 12;
        if (r == 0)
            return '0;
        if (r == 1 && regs.max_payload != 8'hFF)
            return 8'($urandom_range(regs.max_payload + 1, 255));
        if (r == 2 && (regs.max_payload <= 32 || $urandom_range(0, 3) == 0))
            return regs.max_payload;
        return 8'($urandom_range(0, top));
    endfunction

    task automatic send_frame(input logic [slfd_pkg::BYTE_W-1:0] len);
        send_byte(regs.sync_first);
        send_byte(regs.sync_second);
        send_byte(regs.sync_third);
        send_byte(len);
        if (len != '0 && len <= regs.max_payload)
            repeat (len) send_byte(8'($urandom));
    endtask

    // partial pattern, then a byte that most likely breaks it
    task automatic send_broken();
        send_byte(regs.sync_first);
        if ($urandom_range(0, 1))
            send_byte(regs.sync_second);
        send_byte($urandom_range(0, 1) ? regs.sync_first : 8'($urandom));
    endtask

    task automatic run_random_phase(input int n_items);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_frame(pick_length());
            else if (pick < 9)
                send_broken();
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        // pattern 00 00 00 and max 251 straight out of reset
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00});
        send_bytes('{8'h00, 8'h00, 8'h00, 8'hFC});
    endtask

    task automatic test_framing();
        program_regs(8'hA5, 8'h5A, 8'hC3, 8'd8);
        send_bytes('{8'hA5, 8'h5A, 8'hC3, 8'h02, 8'hFF, 8'h00});
        // repeated first sync byte, then an oversize length equal to the first sync byte
        send_bytes('{8'hA5, 8'hA5, 8'h5A, 8'hC3, 8'hA5});
        // pattern broken at its third byte by the first sync byte, then an empty frame
        send_bytes('{8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hC3, 8'h00});
        send_byte(8'h3C);
    endtask

    task automatic test_random_settings();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 40)));
        run_random_phase(110);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
        run_random_phase(80);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
        run_random_phase(100);
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'd7);
        run_random_phase(110);
        program_regs(8'h00, 8'h00, 8'h00, 8'($urandom_range(1, 16)));
        run_random_phase(110);
    endtask

    task automatic test_backpressure();
        program_regs(8'h7E, 8'h81, 8'h55, 8'd16);
        src_gaps_on = 1'b0;
        hold_cycles = 80;
        repeat (5) send_frame(8'd10);
        // pause until the held-back results have all come out
        idle_rx();
        wait_drained();
        src_gaps_on = 1'b1;
        repeat (3) send_frame(pick_length());
    endtask

    task automatic test_quiet_finish();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'd20);
        src_gaps_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random_phase(100);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        regs.sync_first  = '0;
        regs.sync_second = '0;
        regs.sync_third  = '0;
        regs.max_payload = slfd_pkg::MAX_PAYLOAD_RESET;
        parse_phase   = slfd_pkg::PH_SYNC1;
        payload_left  = '0;
        next_is_first = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_framing();
        test_random_settings();
        test_backpressure();
        test_quiet_finish();

        idle_rx();
        wait_drained();
        repeat (6) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
